// File: src/y2rgb_pkg.sv
// Shared types, register codes, luma expansion table and helpers for the YCbCr to RGB packer.
package y2rgb_pkg;

   // Register map
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;
   localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
   localparam logic [2:0] REG_CR_RED_GAIN   = 3'd1;
   localparam logic [2:0] REG_CR_GREEN_GAIN = 3'd2;
   localparam logic [2:0] REG_CB_GREEN_GAIN = 3'd3;
   localparam logic [2:0] REG_CB_BLUE_GAIN  = 3'd4;

   // Reset values
   localparam logic [3:0]  PIXEL_FORMAT_RESET  = 4'd3;
   localparam logic [16:0] CR_RED_GAIN_RESET   = 17'd89850;
   localparam logic [16:0] CR_GREEN_GAIN_RESET = 17'd45744;
   localparam logic [16:0] CB_GREEN_GAIN_RESET = 17'd22020;
   localparam logic [16:0] CB_BLUE_GAIN_RESET  = 17'd113508;

   // Color model codes
   localparam logic [3:0] MODEL_BGR888       = 4'd0;
   localparam logic [3:0] MODEL_BGRA8888     = 4'd1;
   localparam logic [3:0] MODEL_RGB565       = 4'd2;
   localparam logic [3:0] MODEL_RGB888       = 4'd3;
   localparam logic [3:0] MODEL_RGBA8888     = 4'd4;
   localparam logic [3:0] MODEL_601_BGR888   = 4'd5;
   localparam logic [3:0] MODEL_601_BGRA8888 = 4'd6;
   localparam logic [3:0] MODEL_601_RGB565   = 4'd7;
   localparam logic [3:0] MODEL_601_RGB888   = 4'd8;
   localparam logic [3:0] MODEL_601_RGBA8888 = 4'd9;
   localparam logic [3:0] MODEL_RGBA16161616 = 4'd10;

   // Byte counts of the packed formats
   localparam logic [3:0] BYTES_RGB565 = 4'd2;
   localparam logic [3:0] BYTES_24BIT  = 4'd3;
   localparam logic [3:0] BYTES_32BIT  = 4'd4;
   localparam logic [3:0] BYTES_64BIT  = 4'd8;

   // Packing format once the 601 flag is split off
   typedef enum logic [2:0] {
      FMT_BGR888,
      FMT_BGRA8888,
      FMT_RGB565,
      FMT_RGB888,
      FMT_RGBA8888,
      FMT_RGBA16161616
   } pack_fmt_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [63:0] packed_pixel;
      logic [3:0]  byte_count;
   } rsp_word_type;

   // Register file contents seen by the datapath
   typedef struct packed {
      logic [3:0]  pixel_format;
      logic [16:0] cr_red_gain;
      logic [16:0] cr_green_gain;
      logic [16:0] cb_green_gain;
      logic [16:0] cb_blue_gain;
   } cfg_type;

   // 601 luma expansion: clamp(floor((11644*i - 154885) / 10000))
   typedef logic [7:0] luma_rom_type [256];

   function automatic luma_rom_type build_luma_rom();
      luma_rom_type rom;
      int num;
      int val;
      for (int i = 0; i < 256; i++) begin
         num = 11644 * i - 154885;
         if (num < 0) begin
            val = 0;
         end else begin
            val = num / 10000;
            if (val > 255) begin
               val = 255;
            end
         end
         rom[i] = val[7:0];
      end
      return rom;
   endfunction

   localparam luma_rom_type LUMA_ROM = build_luma_rom();

   // Channel sum is signed 13.16; floor to integer and clip to 0..255
   localparam int SumWidth = 29;

   function automatic logic [7:0] clip_channel(input logic signed [SumWidth-1:0] v);
      logic [7:0] res;
      if (v[SumWidth-1]) begin
         res = 8'd0;
      end else if (|v[SumWidth-2:24]) begin
         res = 8'hff;
      end else begin
         res = v[23:16];
      end
      return res;
   endfunction

endpackage

// File: src/y2rgb_csr.sv
// APB-style register file for color model and chroma gains.
module y2rgb_csr import y2rgb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CsrAddrWidth-1:0]  csr_paddr,
   input  logic [CsrDataWidth-1:0]  csr_pwdata,
   output logic [CsrDataWidth-1:0]  csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write decode; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PIXEL_FORMAT:  cfg_in.pixel_format  = csr_pwdata[3:0];
            REG_CR_RED_GAIN:   cfg_in.cr_red_gain   = csr_pwdata[16:0];
            REG_CR_GREEN_GAIN: cfg_in.cr_green_gain = csr_pwdata[16:0];
            REG_CB_GREEN_GAIN: cfg_in.cb_green_gain = csr_pwdata[16:0];
            REG_CB_BLUE_GAIN:  cfg_in.cb_blue_gain  = csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format  <= PIXEL_FORMAT_RESET;
         cfg_ff.cr_red_gain   <= CR_RED_GAIN_RESET;
         cfg_ff.cr_green_gain <= CR_GREEN_GAIN_RESET;
         cfg_ff.cb_green_gain <= CB_GREEN_GAIN_RESET;
         cfg_ff.cb_blue_gain  <= CB_BLUE_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         REG_PIXEL_FORMAT:  csr_prdata = {28'd0, cfg_ff.pixel_format};
         REG_CR_RED_GAIN:   csr_prdata = {15'd0, cfg_ff.cr_red_gain};
         REG_CR_GREEN_GAIN: csr_prdata = {15'd0, cfg_ff.cr_green_gain};
         REG_CB_GREEN_GAIN: csr_prdata = {15'd0, cfg_ff.cb_green_gain};
         REG_CB_BLUE_GAIN:  csr_prdata = {15'd0, cfg_ff.cb_blue_gain};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: src/y2rgb_datapath.sv
// Three-stage conversion pipeline: luma expansion, gain multiplies, sum/clip/pack.
module y2rgb_datapath import y2rgb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int ProdWidth = 27;

   logic advance;
   logic model_ok;
   logic use_601;
   pack_fmt_type fmt_dec;

   // stage 1: expanded luma and centered chroma
   logic              s1_vld_ff, s1_vld_in;
   logic [7:0]        s1_y_ff, s1_y_in;
   logic signed [8:0] s1_cb_ff, s1_cr_ff;
   pack_fmt_type      s1_fmt_ff;

   // stage 2: gain products
   logic                        s2_vld_ff;
   logic [7:0]                  s2_y_ff;
   logic signed [ProdWidth-1:0] s2_r_prod_ff, s2_gr_prod_ff, s2_gb_prod_ff, s2_b_prod_ff;
   logic signed [ProdWidth-1:0] s2_r_prod_in, s2_gr_prod_in, s2_gb_prod_in, s2_b_prod_in;
   pack_fmt_type                s2_fmt_ff;

   // stage 3: result register
   logic                       out_vld_ff;
   rsp_word_type               out_ff, out_in;
   logic signed [SumWidth-1:0] y_scaled, r_sum, g_sum, b_sum;
   logic [7:0]                 r_ch, g_ch, b_ch;

   // whole pipeline moves when the result register is free or being drained
   assign advance   = !out_vld_ff || rsp_ready;
   assign req_ready = advance;

   // color model decode; undefined models drop the word
   always_comb begin
      model_ok = 1'b1;
      use_601  = 1'b0;
      fmt_dec  = FMT_RGB888;
      unique case (cfg.pixel_format) inside
         MODEL_BGR888:       fmt_dec = FMT_BGR888;
         MODEL_BGRA8888:     fmt_dec = FMT_BGRA8888;
         MODEL_RGB565:       fmt_dec = FMT_RGB565;
         MODEL_RGB888:       fmt_dec = FMT_RGB888;
         MODEL_RGBA8888:     fmt_dec = FMT_RGBA8888;
         MODEL_601_BGR888:   begin fmt_dec = FMT_BGR888;   use_601 = 1'b1; end
         MODEL_601_BGRA8888: begin fmt_dec = FMT_BGRA8888; use_601 = 1'b1; end
         MODEL_601_RGB565:   begin fmt_dec = FMT_RGB565;   use_601 = 1'b1; end
         MODEL_601_RGB888:   begin fmt_dec = FMT_RGB888;   use_601 = 1'b1; end
         MODEL_601_RGBA8888: begin fmt_dec = FMT_RGBA8888; use_601 = 1'b1; end
         MODEL_RGBA16161616: fmt_dec = FMT_RGBA16161616;
         default:            model_ok = 1'b0;
      endcase
   end

   assign s1_vld_in = req_valid && model_ok;
   assign s1_y_in   = use_601 ? LUMA_ROM[req_data.luma] : req_data.luma;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_y_ff   <= s1_y_in;
         s1_cb_ff  <= $signed({1'b0, req_data.chroma_blue}) - 9'sd128;
         s1_cr_ff  <= $signed({1'b0, req_data.chroma_red}) - 9'sd128;
         s1_fmt_ff <= fmt_dec;
      end
   end

   // gain products, 17-bit unsigned gain by 9-bit signed chroma
   assign s2_r_prod_in  = $signed({1'b0, cfg.cr_red_gain})   * s1_cr_ff;
   assign s2_gr_prod_in = $signed({1'b0, cfg.cr_green_gain}) * s1_cr_ff;
   assign s2_gb_prod_in = $signed({1'b0, cfg.cb_green_gain}) * s1_cb_ff;
   assign s2_b_prod_in  = $signed({1'b0, cfg.cb_blue_gain})  * s1_cb_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_y_ff       <= s1_y_ff;
         s2_r_prod_ff  <= s2_r_prod_in;
         s2_gr_prod_ff <= s2_gr_prod_in;
         s2_gb_prod_ff <= s2_gb_prod_in;
         s2_b_prod_ff  <= s2_b_prod_in;
         s2_fmt_ff     <= s1_fmt_ff;
      end
   end

   // channel sums in signed 13.16, then floor and clip
   assign y_scaled = $signed({5'd0, s2_y_ff, 16'd0});
   assign r_sum = y_scaled + SumWidth'(s2_r_prod_ff);
   assign g_sum = y_scaled - SumWidth'(s2_gr_prod_ff) - SumWidth'(s2_gb_prod_ff);
   assign b_sum = y_scaled + SumWidth'(s2_b_prod_ff);
   assign r_ch  = clip_channel(r_sum);
   assign g_ch  = clip_channel(g_sum);
   assign b_ch  = clip_channel(b_sum);

   // pixel packing, first memory byte in the low bits, alpha zero
   always_comb begin
      out_in.red   = r_ch;
      out_in.green = g_ch;
      out_in.blue  = b_ch;
      case (s2_fmt_ff)
         FMT_BGR888: begin
            out_in.packed_pixel = {40'd0, r_ch, g_ch, b_ch};
            out_in.byte_count   = BYTES_24BIT;
         end
         FMT_BGRA8888: begin
            out_in.packed_pixel = {40'd0, r_ch, g_ch, b_ch};
            out_in.byte_count   = BYTES_32BIT;
         end
         FMT_RGB565: begin
            out_in.packed_pixel = {48'd0, r_ch[7:3], g_ch[7:2], b_ch[7:3]};
            out_in.byte_count   = BYTES_RGB565;
         end
         FMT_RGB888: begin
            out_in.packed_pixel = {40'd0, b_ch, g_ch, r_ch};
            out_in.byte_count   = BYTES_24BIT;
         end
         FMT_RGBA8888: begin
            out_in.packed_pixel = {40'd0, b_ch, g_ch, r_ch};
            out_in.byte_count   = BYTES_32BIT;
         end
         default: begin
            out_in.packed_pixel = {16'd0, 8'd0, b_ch, 8'd0, g_ch, 8'd0, r_ch};
            out_in.byte_count   = BYTES_64BIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s1_vld_ff;
         out_vld_ff <= s2_vld_ff;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // undefined color model never enters the pipeline
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !model_ok |=> !s1_vld_ff)
      else $error("dropped word entered pipeline");

   // a held pipeline keeps its words
   assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff && !advance |=> s2_vld_ff && out_vld_ff)
      else $error("word lost while stalled");

   // byte count is one of the packed sizes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_count == BYTES_RGB565 || rsp_data.byte_count == BYTES_24BIT
                     || rsp_data.byte_count == BYTES_32BIT
                     || rsp_data.byte_count == BYTES_64BIT))
      else $error("bad byte count");

   // bits above the low three bytes are zero unless the byte count is eight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_count != BYTES_64BIT |-> rsp_data.packed_pixel[63:24] == '0)
      else $error("packed pixel has bits past byte count");

endmodule

// File: src/ycbcr_to_rgb_pixel_pack.sv
// Top level of the YCbCr to RGB converter and pixel packer.
//
//   port group   dir   handshake              carries
//   req_*        in    req_valid/req_ready    luma, Cb, Cr word
//   rsp_*        out   rsp_valid/rsp_ready    clipped RGB and packed pixel word
//   csr_*        in    APB psel/penable       color model and four chroma gains
//
// One word per clock sustained while results drain; a word reaches rsp_valid through
// three register stages (luma table, gain multiply, sum/clip/pack result register).
// A held result word (rsp_valid high, rsp_ready low) stalls the whole pipeline.
// Words sent under an undefined color model (11..15) are accepted and dropped.
// Reset is synchronous and restores the register defaults; no warm-up pass.
module ycbcr_to_rgb_pixel_pack import y2rgb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_word_type            req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_word_type            rsp_data,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type cfg;

   // configuration registers
   y2rgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // conversion pipeline
   y2rgb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
